// ===== hw/rtl/rcec_pkg.sv =====
// Shared types, constants and helpers for the rotate cipher ECB/CBC engine.
package rcec_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int POS_W       = $clog2(BLOCK_BYTES);
    localparam int KEY_W       = 48;
    localparam int IV_W        = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_ROT = 3'd0,
        CFG_IV_LO   = 3'd1,
        CFG_IV_HI   = 3'd2,
        CFG_MODE    = 3'd3,
        CFG_DIR     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [KEY_W-1:0] key_rot;
        logic [IV_W-1:0]  iv_lo;
        logic [IV_W-1:0]  iv_hi;
        logic             cbc;
        logic             dec;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_item;

    function automatic logic [7:0] rot_left(input logic [7:0] v, input logic [2:0] r);
        logic [15:0] t;
        t = {v, v} << r;
        return t[15:8];
    endfunction

    function automatic logic [7:0] rot_right(input logic [7:0] v, input logic [2:0] r);
        logic [15:0] t;
        t = {v, v} >> r;
        return t[7:0];
    endfunction

endpackage

// ===== hw/rtl/rotate_cipher_ecb_cbc_engine_top.sv =====
// Top level of the byte-rotation cipher engine with ECB and CBC chaining.
// Each accepted byte yields one output byte, one per cycle while the output is
// not stalled, passing through the queue and then the output register. A byte
// flagged last that ends inside a block is followed by zero pad bytes up to the
// block boundary, one per cycle while the output is not stalled, and no new
// byte leaves the queue while padding. tlast marks the last output byte
// of each request and tuser the final byte of the padded message. Configuration
// writes take effect at once; the user must make them only while the engine is
// idle, and the block does not enforce this. An IV write reloads the whole chain.
module rotate_cipher_ecb_cbc_engine_top import rcec_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // [7:0] data_byte
    input  logic                  i_s_axis_tlast,   // message_last
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [7:0]            o_m_axis_tdata,   // [7:0] out_byte
    output logic                  o_m_axis_tlast,   // run_last
    output logic                  o_m_axis_tuser    // [0] message_end
);

    t_cfg  cfg;
    logic  iv_load;
    logic  q_full;
    logic  q_push;
    t_item q_in;
    logic  q_pop;
    logic  q_valid;
    t_item q_out;

    rcec_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_valid  (i_s_axis_tvalid),
        .i_s_data   (i_s_axis_tdata),
        .i_s_last   (i_s_axis_tlast),
        .o_s_ready  (o_s_axis_tready),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_item   (q_in),
        .o_cfg      (cfg),
        .o_iv_load  (iv_load)
    );

    rcec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out)
    );

    rcec_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_iv_load (iv_load),
        .i_q_valid (q_valid),
        .i_q_item  (q_out),
        .o_q_pop   (q_pop),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_m_data  (o_m_axis_tdata),
        .o_m_last  (o_m_axis_tlast),
        .o_m_end   (o_m_axis_tuser)
    );

endmodule

// ===== hw/rtl/rcec_front.sv =====
// Front end: configuration registers and input request acceptance into the queue.
module rcec_front import rcec_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_valid,
    input  logic [7:0]            i_s_data,
    input  logic                  i_s_last,
    output logic                  o_s_ready,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output t_item                 o_q_item,
    output t_cfg                  o_cfg,
    output logic                  o_iv_load
);

    t_cfg r_cfg;
    logic r_iv_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= '0;
            r_iv_load <= 1'b0;
        end else begin
            r_iv_load <= 1'b0;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_KEY_ROT: r_cfg.key_rot <= i_cfg_data[KEY_W-1:0];
                    CFG_IV_LO: begin
                        r_cfg.iv_lo <= i_cfg_data[IV_W-1:0];
                        r_iv_load   <= 1'b1;
                    end
                    CFG_IV_HI: begin
                        r_cfg.iv_hi <= i_cfg_data[IV_W-1:0];
                        r_iv_load   <= 1'b1;
                    end
                    CFG_MODE:    r_cfg.cbc <= i_cfg_data[0];
                    CFG_DIR:     r_cfg.dec <= i_cfg_data[0];
                    default:     ;
                endcase
            end
        end
    end

    assign o_s_ready      = !i_q_full;
    assign o_q_push       = i_s_valid && !i_q_full;
    assign o_q_item.data  = i_s_data;
    assign o_q_item.last  = i_s_last;
    assign o_cfg          = r_cfg;
    assign o_iv_load      = r_iv_load;

endmodule

// ===== hw/rtl/rcec_queue.sv =====
// Short request queue between the front end and the cipher back end.
module rcec_queue import rcec_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wp;
    logic [QPTR_W-1:0]  r_rp;
    logic [QCNT_W-1:0]  r_cnt;
    logic               pop_ok;

    assign pop_ok = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, pop_ok})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

endmodule

// ===== hw/rtl/rcec_back.sv =====
// Back end: byte rotation, chaining, end-of-message padding and output register.
module rcec_back import rcec_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_iv_load,
    input  logic       i_q_valid,
    input  t_item      i_q_item,
    output logic       o_q_pop,
    output logic       o_m_valid,
    input  logic       i_m_ready,
    output logic [7:0] o_m_data,
    output logic       o_m_last,
    output logic       o_m_end
);

    logic [7:0]       r_chain [BLOCK_BYTES];
    logic [POS_W-1:0] r_pos;
    logic             r_pad;
    logic             r_vld;
    logic [7:0]       r_data;
    logic             r_last;
    logic             r_end;

    logic             adv;
    logic             go;
    logic [7:0]       b;
    logic             last;
    logic [2:0]       amt;
    logic [7:0]       ch;
    logic [7:0]       res;
    logic [7:0]       ch_nx;
    logic [POS_W-1:0] pos_nx;
    logic             msg_end;

    always_comb begin
        adv     = !r_vld || i_m_ready;
        go      = adv && (r_pad || i_q_valid);
        b       = r_pad ? 8'h00 : i_q_item.data;
        last    = r_pad || i_q_item.last;
        amt     = i_cfg.key_rot[3*r_pos +: 3];
        ch      = r_chain[r_pos];
        if (!i_cfg.dec) begin
            res   = rot_left(i_cfg.cbc ? (b ^ ch) : b, amt);
            ch_nx = res;
        end else begin
            res   = rot_right(b, amt) ^ (i_cfg.cbc ? ch : 8'h00);
            ch_nx = b;
        end
        pos_nx  = (r_pos == POS_W'(BLOCK_BYTES - 1)) ? '0 : r_pos + 1'b1;
        msg_end = last && (pos_nx == '0);
    end

    assign o_q_pop = adv && !r_pad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_pad <= 1'b0;
            r_vld <= 1'b0;
            for (int j = 0; j < BLOCK_BYTES; j++) begin
                r_chain[j] <= 8'h00;
            end
        end else begin
            if (adv) begin
                r_vld <= go;
            end
            if (go) begin
                r_pos <= pos_nx;
                r_pad <= last && !msg_end;
                if (i_cfg.cbc) begin
                    r_chain[r_pos] <= ch_nx;
                end
            end
            if ((go && msg_end) || i_iv_load) begin
                for (int j = 0; j < BLOCK_BYTES; j++) begin
                    r_chain[j] <= (j < 8) ? i_cfg.iv_lo[(j % 8) * 8 +: 8]
                                          : i_cfg.iv_hi[(j % 8) * 8 +: 8];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_data <= res;
            r_last <= !last || msg_end;
            r_end  <= msg_end;
        end
    end

    assign o_m_valid = r_vld;
    assign o_m_data  = r_data;
    assign o_m_last  = r_last;
    assign o_m_end   = r_end;

endmodule

// ===== hw/rtl/rcec_checker.sv =====
// Port-level assertion checker for the cipher engine, bound to the top level.
module rcec_checker import rcec_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast,
    input logic       o_m_axis_tuser
);

    logic             in_acc;
    logic             out_acc;
    logic [POS_W-1:0] r_beats;
    logic [3:0]       r_pend;

    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;

    // output beats within the current message, modulo the block size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beats <= '0;
        end else if (out_acc) begin
            r_beats <= (o_m_axis_tuser || r_beats == POS_W'(BLOCK_BYTES - 1)) ? '0
                                                                             : r_beats + 1'b1;
        end
    end

    // requests accepted but not yet closed by a tlast beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {3'b000, in_acc} - {3'b000, out_acc && o_m_axis_tlast};
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)
            && $stable(o_m_axis_tuser))
        else $error("output beat changed while stalled");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("message end without request end");

    a_end_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && o_m_axis_tuser |-> r_beats == POS_W'(BLOCK_BYTES - 1))
        else $error("padded message not a whole number of blocks");

    a_last_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && o_m_axis_tlast |-> r_pend != 4'd0)
        else $error("request end with no request outstanding");

endmodule

bind rotate_cipher_ecb_cbc_engine_top rcec_checker u_rcec_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
